// ----- hdl/suspension_spring_damper_force_defines.svh -----
// Assertion macros shared by the suspension force design.
`ifndef SUSPENSION_SPRING_DAMPER_FORCE_DEFINES_SVH
`define SUSPENSION_SPRING_DAMPER_FORCE_DEFINES_SVH

// Asserts that a condition implies another condition at the same clock edge.
`define SSDF_ASSERT_IMP(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

// Asserts that a condition implies another condition at the next clock edge.
`define SSDF_ASSERT_NXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ----- hdl/ssdf_pkg.sv -----
package ssdf_pkg;

  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned CoordWidth    = 32;
  localparam int unsigned LenWidth      = 31;
  localparam int unsigned DtWidth       = 16;
  localparam int unsigned CfgIdxWidth   = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] RegStiffness  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegDampComp   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegDampReb    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegLengthMin  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegLengthMax  = 3'd4;

  // Item passed from the front part to the back part through the queue.
  typedef struct packed {
    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] dz;
    logic [15:0] dt;
    logic [31:0] anti_roll;
  } ssdf_item_t;

endpackage

// ----- hdl/ssdf_front.sv -----
module ssdf_front import ssdf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [31:0]       mount_x_i,
  input  logic [31:0]       mount_y_i,
  input  logic [31:0]       mount_z_i,
  input  logic [31:0]       wheel_x_i,
  input  logic [31:0]       wheel_y_i,
  input  logic [31:0]       wheel_z_i,
  input  logic [15:0]       time_step_i,
  input  logic [31:0]       anti_roll_force_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output ssdf_item_t        q_item_o
);

  // Two-entry queue between front and back parts.
  ssdf_item_t mem_q [2];
  logic       wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;
  ssdf_item_t item;
  logic       push, pop;

  function automatic logic [32:0] absdiff(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? 33'(-d) : d;
  endfunction

  // Build the item: absolute differences, clean frame time and anti-roll.
  always_comb begin
    item.dx = absdiff(wheel_x_i, mount_x_i);
    item.dy = absdiff(wheel_y_i, mount_y_i);
    item.dz = absdiff(wheel_z_i, mount_z_i);
    item.dt = (time_step_i == '0) ? 16'd1 : time_step_i;
    item.anti_roll = anti_roll_force_i[31] ? 32'd0 : anti_roll_force_i;
  end

  assign ready_o   = (cnt_q != 2'd2);
  assign push      = valid_i && ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_item_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= item;
    end
  end

endmodule

// ----- hdl/ssdf_back.sv -----
`include "suspension_spring_damper_force_defines.svh"
module ssdf_back import ssdf_pkg::*; #(
  parameter int unsigned ValueWidth = ValueWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  ssdf_item_t            q_item_i,
  input  logic [31:0]           stiffness_i,
  input  logic [31:0]           damp_comp_i,
  input  logic [31:0]           damp_reb_i,
  input  logic [30:0]           length_min_i,
  input  logic [30:0]           length_max_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [ValueWidth-1:0] spring_force_o,
  output logic [30:0]           spring_length_o
);

  // Sequencer states.
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSq    = 4'd1;
  localparam logic [3:0] StSqrt  = 4'd2;
  localparam logic [3:0] StClamp = 4'd3;
  localparam logic [3:0] StMul   = 4'd4;
  localparam logic [3:0] StDiv   = 4'd5;
  localparam logic [3:0] StSum   = 4'd6;
  localparam logic [3:0] StOut   = 4'd7;
  localparam logic [3:0] StTot   = 4'd8;

  logic [3:0]  state_q;
  logic [1:0]  sel_q;
  logic [5:0]  cnt_q;
  ssdf_item_t  it_q;
  logic [63:0] acc_q;          // sum of squares, shifted out two bits per root step
  logic [31:0] res_q;          // square root result
  logic [32:0] sr_rem_q;       // square root partial remainder
  logic        sat_q;
  logic [30:0] cur_q;
  logic [30:0] last_q;
  logic        last_vld_q;
  logic [63:0] s_q, p_q;
  logic        comp_q, pos_q;
  logic [63:0] quo_q;          // quotient in Q.16
  logic [16:0] rem_q;
  logic [63:0] tot_q;
  logic [ValueWidth-1:0] force_q;
  logic        out_vld_q;

  logic [32:0] sq_in;
  logic [65:0] sq_prod;
  logic [34:0] sr_next, sr_sub;
  logic [30:0] prev;
  logic [63:0] lim, d_val, tot;
  logic [64:0] tsum;
  logic [48:0] fsum;

  assign q_ready_o = (state_q == StIdle) && !out_vld_q;
  assign valid_o   = out_vld_q;
  assign spring_force_o  = force_q;
  assign spring_length_o = cur_q;

  always_comb begin
    case (sel_q)
      2'd0:    sq_in = it_q.dx;
      2'd1:    sq_in = it_q.dy;
      default: sq_in = it_q.dz;
    endcase
    sq_prod = sq_in * sq_in;
    // One bit of the restoring square root per step, two radicand bits.
    sr_next = {sr_rem_q, acc_q[63:62]};
    sr_sub  = {1'b0, res_q, 2'b01};
    prev  = last_vld_q ? last_q : length_max_i;
    lim   = s_q + (s_q >> 1);
    d_val = (quo_q > lim) ? lim : quo_q;
    tsum  = {1'b0, s_q} + {1'b0, d_val};
    if (!pos_q) begin
      tot = '0;
    end else if (comp_q) begin
      tot = tsum[64] ? '1 : tsum[63:0];
    end else begin
      tot = (d_val < s_q) ? s_q - d_val : '0;
    end
    fsum = {1'b0, tot_q[63:16]} + {17'b0, it_q.anti_roll};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      out_vld_q  <= 1'b0;
      last_vld_q <= 1'b0;
      sel_q      <= '0;
      cnt_q      <= '0;
    end else begin
      if (out_vld_q && ready_i) out_vld_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (q_valid_i && q_ready_o) begin
            it_q    <= q_item_i;
            acc_q   <= '0;
            sel_q   <= '0;
            state_q <= StSq;
          end
        end
        StSq: begin
          acc_q <= acc_q + sq_prod[63:0];
          if (sel_q == 2'd2) begin
            sat_q    <= it_q.dx[32] | it_q.dx[31] | it_q.dy[31] | it_q.dz[31] |
                        it_q.dy[32] | it_q.dz[32];
            state_q  <= StSqrt;
            cnt_q    <= '0;
            res_q    <= '0;
            sr_rem_q <= '0;
          end else begin
            sel_q <= sel_q + 2'd1;
          end
        end
        StSqrt: begin
          if (cnt_q == 6'd0 && acc_q[63:62] != 2'b00) sat_q <= 1'b1;
          acc_q <= {acc_q[61:0], 2'b00};
          if (sr_next >= sr_sub) begin
            sr_rem_q <= 33'(sr_next - sr_sub);
            res_q    <= {res_q[30:0], 1'b1};
          end else begin
            sr_rem_q <= sr_next[32:0];
            res_q    <= {res_q[30:0], 1'b0};
          end
          if (cnt_q == 6'd31) state_q <= StClamp;
          cnt_q <= cnt_q + 6'd1;
        end
        StClamp: begin
          // A saturated distance is above any maximum length.
          if (sat_q || res_q[31]) begin
            cur_q <= length_max_i;
          end else if (res_q[30:0] < length_min_i) begin
            cur_q <= length_min_i;
          end else if (res_q[30:0] > length_max_i) begin
            cur_q <= length_max_i;
          end else begin
            cur_q <= res_q[30:0];
          end
          state_q <= StMul;
        end
        StMul: begin
          pos_q  <= (length_max_i > cur_q) && (stiffness_i != '0);
          s_q    <= stiffness_i * {33'b0, length_max_i - cur_q};
          comp_q <= cur_q < prev;
          p_q    <= (cur_q < prev) ? damp_comp_i * {33'b0, prev - cur_q}
                                   : damp_reb_i * {33'b0, cur_q - prev};
          last_q     <= cur_q;
          last_vld_q <= 1'b1;
          quo_q   <= '0;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          // Shift-subtract divide of p * 2^16 by dt, 80 quotient bits, 2 per cycle.
          begin : div_blk
            logic [16:0] r1, r2;
            logic [63:0] q1;
            logic [79:0] pn;
            pn = {p_q, 16'b0} << {cnt_q, 1'b0};
            r1 = {rem_q[15:0], pn[79]};
            q1 = {quo_q[62:0], r1 >= {1'b0, it_q.dt}};
            if (r1 >= {1'b0, it_q.dt}) r1 = r1 - {1'b0, it_q.dt};
            r2 = {r1[15:0], pn[78]};
            quo_q <= (quo_q[63:62] != 2'b00 || q1[63]) ? '1
                     : {q1[62:0], r2 >= {1'b0, it_q.dt}};
            rem_q <= (r2 >= {1'b0, it_q.dt}) ? r2 - {1'b0, it_q.dt} : r2;
          end
          if (cnt_q == 6'd39) state_q <= StTot;
          cnt_q <= cnt_q + 6'd1;
        end
        StTot: begin
          // Clamp the damping term and combine it with the spring term.
          tot_q   <= tot;
          state_q <= StSum;
        end
        StSum: begin
          if (fsum > {{(49-ValueWidth){1'b0}}, {ValueWidth{1'b1}}})
            force_q <= '1;
          else
            force_q <= fsum[ValueWidth-1:0];
          state_q <= StOut;
        end
        StOut: begin
          out_vld_q <= 1'b1;
          state_q   <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `SSDF_ASSERT_IMP(a_out_idle, clk_i, rst_ni, out_vld_q, state_q == StIdle)
  `SSDF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_vld_q && !ready_i, out_vld_q)
  `SSDF_ASSERT_IMP(a_len_max, clk_i, rst_ni, out_vld_q && length_min_i <= length_max_i,
                   cur_q <= length_max_i)

endmodule

// ----- hdl/suspension_spring_damper_force.sv -----
// Suspension spring and damper force for one wheel.
// Input channel (in_valid_i/in_ready_o) takes mount point, wheel centre,
// frame time and anti-roll force. Output channel (out_valid_o/out_ready_i)
// returns the force and the clamped spring length, one result per item.
// Configuration writes (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
// set stiffness, damping coefficients and length limits; write only while idle.
// From input acceptance to a valid result, an item leaves the queue, is
// squared and summed per axis, passes 32 square root steps, a clamp and a
// multiply, runs through the divider at two quotient bits per step, and then
// the terms are combined, saturated and the result is presented.
// The back part takes one item at a time, the next only when idle with no
// result waiting; a two-entry queue holds accepted items meanwhile.
// Reset clears the control state and the configuration registers; the
// previous length then reads as length_max.
// If the receiver stalls, the result holds on the output and further items
// wait in the queue until it is taken.
module suspension_spring_damper_force import ssdf_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [31:0]            mount_x_i,
  input  logic [31:0]            mount_y_i,
  input  logic [31:0]            mount_z_i,
  input  logic [31:0]            wheel_x_i,
  input  logic [31:0]            wheel_y_i,
  input  logic [31:0]            wheel_z_i,
  input  logic [15:0]            time_step_i,
  input  logic [31:0]            anti_roll_force_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0] spring_force_o,
  output logic [30:0]            spring_length_o
);

  logic [31:0] stiff_q, dcomp_q, dreb_q;
  logic [30:0] lmin_q, lmax_q;
  logic        qv, qr;
  ssdf_item_t  qi;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q <= '0;
      dcomp_q <= '0;
      dreb_q  <= '0;
      lmin_q  <= '0;
      lmax_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegStiffness: stiff_q <= cfg_data_i;
        RegDampComp:  dcomp_q <= cfg_data_i;
        RegDampReb:   dreb_q  <= cfg_data_i;
        RegLengthMin: lmin_q  <= cfg_data_i[30:0];
        RegLengthMax: lmax_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  ssdf_front u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .mount_x_i, .mount_y_i, .mount_z_i, .wheel_x_i, .wheel_y_i, .wheel_z_i,
    .time_step_i, .anti_roll_force_i,
    .q_valid_o(qv), .q_ready_i(qr), .q_item_o(qi)
  );

  ssdf_back #(.ValueWidth(VALUE_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qv), .q_ready_o(qr), .q_item_i(qi),
    .stiffness_i(stiff_q), .damp_comp_i(dcomp_q), .damp_reb_i(dreb_q),
    .length_min_i(lmin_q), .length_max_i(lmax_q),
    .valid_o(out_valid_o), .ready_i(out_ready_i),
    .spring_force_o, .spring_length_o
  );

endmodule
